[src/timer_table_expiry_scan_macros.svh]
// Assertion macros for the timer table expiry scan block.
`ifndef TIMER_TABLE_EXPIRY_SCAN_MACROS_SVH
`define TIMER_TABLE_EXPIRY_SCAN_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define TTES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define TTES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ttes_pkg.sv]
// Shared types, operation codes and defaults for the timer table expiry scan.
package ttes_pkg;

  // Default sizes of the slot table.
  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int DATA_BITS_DEF = 32;

  // Operation codes.
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_INIT   = 3'd1;
  localparam logic [2:0] OP_ADD    = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_MODIFY = 3'd4;

  // Result kinds.
  localparam logic KIND_FIRE = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Input word.
  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  slot;
    logic [31:0] expiry;
    logic [31:0] payload;
    logic        has_handler;
  } item_t;

  // Result word.
  typedef struct packed {
    logic        kind;
    logic [3:0]  fired_slot;
    logic [31:0] fired_data;
    logic        flag;
    logic [31:0] now;
    logic [4:0]  armed_count;
    logic        last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec_op;
    logic tick_start;
    logic scan_step;
    logic emit_done;
  } ttes_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } ttes_status_t;

endpackage

[src/ttes_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ttes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/ttes_ctrl.sv]
// Controller state machine: sequences single operations and the tick scan.
module ttes_ctrl import ttes_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [2:0]   op,
  input  ttes_status_t status,
  output ttes_cmd_t    cmd,
  output logic         busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (op == OP_TICK) begin
            cmd.tick_start = 1'b1;
            state_next     = S_SCAN;
          end else begin
            cmd.exec_op = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.emit_done = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[src/ttes_dpath.sv]
// Datapath: tick counter, armed flags, slot memory, scan index and result register.
module ttes_dpath import ttes_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  ttes_cmd_t    cmd,
  input  item_t        item,
  output ttes_status_t status,
  output result_t      result,
  output logic         result_strobe
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int WORD_W = TIME_BITS + DATA_BITS;

  logic [TIME_BITS-1:0] count;
  logic [SLOTS-1:0]     armed;
  logic [CNT_W-1:0]     total;
  logic [IDX_W-1:0]     idx;

  // Slot addressing of the incoming operation.
  logic [6:0]       slot_wide;
  logic             slot_ok;
  logic [IDX_W-1:0] slot_idx;
  logic             armed_cur;

  assign slot_wide = 7'(item.slot);
  assign slot_ok   = (slot_wide < 7'(SLOTS));
  assign slot_idx  = IDX_W'(slot_wide);
  assign armed_cur = armed[slot_idx];

  // Operation decode: new armed bit, memory write and flag.
  logic             armed_new;
  logic             op_we;
  logic [WORD_W-1:0] op_word;
  logic             op_flag;

  always_comb begin
    armed_new = armed_cur;
    op_we     = 1'b0;
    op_flag   = 1'b0;
    op_word   = {TIME_BITS'(item.expiry), DATA_BITS'(item.payload)};
    case (item.op)
      OP_INIT: begin
        armed_new = 1'b0;
        op_we     = 1'b1;
        op_word   = '0;
      end
      OP_ADD: begin
        if (!armed_cur) begin
          op_we     = 1'b1;
          armed_new = item.has_handler;
          op_flag   = item.has_handler;
        end
      end
      OP_DELETE: begin
        op_flag   = armed_cur;
        armed_new = 1'b0;
      end
      OP_MODIFY: begin
        op_flag   = armed_cur;
        op_we     = 1'b1;
        armed_new = item.has_handler;
      end
      default: begin
        armed_new = armed_cur;
      end
    endcase
    if (!slot_ok) begin
      armed_new = armed_cur;
      op_we     = 1'b0;
      op_flag   = 1'b0;
    end
  end

  // Armed count after the operation.
  logic [CNT_W-1:0] op_total;

  always_comb begin
    op_total = total;
    if (armed_new && !armed_cur) begin
      op_total = total + CNT_W'(1);
    end else if (!armed_new && armed_cur) begin
      op_total = total - CNT_W'(1);
    end
  end

  // Slot memory holds expiry and data word per slot.
  logic [IDX_W-1:0]  raddr;
  logic [WORD_W-1:0] rd_word;
  logic              scan_last;

  assign scan_last = (idx == IDX_W'(SLOTS - 1));
  assign raddr     = (cmd.tick_start || scan_last) ? '0 : idx + IDX_W'(1);
  assign status.scan_last = scan_last;

  ttes_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (cmd.exec_op && op_we),
    .waddr (slot_idx),
    .wdata (op_word),
    .raddr (raddr),
    .rdata (rd_word)
  );

  // A scanned slot fires when armed and its expiry is at or below the count.
  logic [TIME_BITS-1:0] rd_exp;
  logic [DATA_BITS-1:0] rd_data;
  logic                 hit;

  assign rd_exp  = rd_word[WORD_W-1 -: TIME_BITS];
  assign rd_data = rd_word[DATA_BITS-1:0];
  assign hit     = armed[idx] && (rd_exp <= count);

  // Counter, armed flags, total and scan index.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      armed <= '0;
      total <= '0;
      idx   <= '0;
    end else begin
      if (cmd.tick_start) begin
        count <= count + TIME_BITS'(1);
        idx   <= '0;
      end else if (cmd.scan_step) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.exec_op) begin
        armed[slot_idx] <= armed_new;
        total           <= op_total;
      end else if (cmd.scan_step && hit) begin
        armed[idx] <= 1'b0;
        total      <= total - CNT_W'(1);
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.exec_op || (cmd.scan_step && hit) || cmd.emit_done;
    end
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (cmd.exec_op) begin
      result.kind        <= KIND_DONE;
      result.fired_slot  <= item.slot;
      result.fired_data  <= '0;
      result.flag        <= op_flag;
      result.now         <= 32'(count);
      result.armed_count <= 5'(op_total);
      result.last        <= 1'b1;
    end else if (cmd.scan_step) begin
      result.kind        <= KIND_FIRE;
      result.fired_slot  <= 4'(idx);
      result.fired_data  <= 32'(rd_data);
      result.flag        <= 1'b0;
      result.now         <= 32'(count);
      result.armed_count <= 5'(total - CNT_W'(1));
      result.last        <= 1'b0;
    end else if (cmd.emit_done) begin
      result.kind        <= KIND_DONE;
      result.fired_slot  <= '0;
      result.fired_data  <= '0;
      result.flag        <= 1'b0;
      result.now         <= 32'(count);
      result.armed_count <= 5'(total);
      result.last        <= 1'b1;
    end
  end

endmodule

[src/timer_table_expiry_scan.sv]
// Top level of the timer table expiry scan block.
// A word is taken when start is high and busy is low; each result word is registered
// and shows on result for one cycle with result_strobe high, and the receiver cannot
// stall it. Init, add, delete and modify do not raise busy, so they may follow each
// other every cycle. A tick holds busy through the scan and the done word, and no
// new word is taken meanwhile: the slot memory has one read port, so the scan reads
// one slot per cycle and may emit one fire word per slot, then one done word with
// last set.
module timer_table_expiry_scan import ttes_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output result_t result,
  output logic    result_strobe
);

`include "timer_table_expiry_scan_macros.svh"

  ttes_cmd_t    cmd;
  ttes_status_t status;

  // Controller.
  ttes_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (item.op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Datapath.
  ttes_dpath #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .item          (item),
    .status        (status),
    .result        (result),
    .result_strobe (result_strobe)
  );

  // An accepted tick starts the scan.
  `TTES_ASSERT_NEXT(a_tick_busy, start && !busy && item.op == OP_TICK, busy, "tick did not start a scan")
  // The final word of an item leaves the block ready for the next one.
  `TTES_ASSERT_NOW(a_last_idle, result_strobe && result.last, !busy, "busy after final word")
  // Fire words only come out during a scan.
  `TTES_ASSERT_NOW(a_fire_busy, result_strobe && !result.last, busy && result.kind == KIND_FIRE, "fire word outside a scan")

endmodule

[bench/tb_timer_table_expiry_scan.sv]
// Self-checking testbench for the timer table expiry scan block.
module tb_timer_table_expiry_scan import ttes_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS = SLOTS_DEF;
  localparam int RANDOM_WORDS = 148;
  // Trailing part of the random traffic that runs with no sender gaps.
  localparam int BURST_TAIL = 40;
  // A tick keeps the block busy for one scan plus the done word.
  localparam int SCAN_CYCLES = NUM_SLOTS + 4;
  localparam int unsigned CYCLE_LIMIT = 100000;
  // Op codes the block does not define.
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  result_t result;
  logic    result_strobe;

  timer_table_expiry_scan uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .item          (item),
    .busy          (busy),
    .result        (result),
    .result_strobe (result_strobe)
  );

  // Predicted timer table state.
  logic        slot_armed [NUM_SLOTS];
  logic        slot_has_cb [NUM_SLOTS];
  logic [31:0] slot_expiry [NUM_SLOTS];
  logic [31:0] slot_data [NUM_SLOTS];
  logic [31:0] tick_now;
  logic [4:0]  armed_total;

  result_t     pending_results [$];
  int          mismatches = 0;
  int unsigned cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic item_t make_item(logic [2:0] op, int slot, logic [31:0] expiry,
                                      logic [31:0] payload, logic has_handler);
    item_t w;
    w.op          = op;
    w.slot        = 4'(slot);
    w.expiry      = expiry;
    w.payload     = payload;
    w.has_handler = has_handler;
    return w;
  endfunction

  function automatic result_t make_result(logic kind, logic [3:0] slot, logic [31:0] data,
                                          logic flag, logic last);
    result_t r;
    r.kind        = kind;
    r.fired_slot  = slot;
    r.fired_data  = data;
    r.flag        = flag;
    r.now         = tick_now;
    r.armed_count = armed_total;
    r.last        = last;
    return r;
  endfunction

  function automatic void clear_table();
    for (int s = 0; s < NUM_SLOTS; s++) begin
      slot_armed[s]  = 1'b0;
      slot_has_cb[s] = 1'b0;
      slot_expiry[s] = '0;
      slot_data[s]   = '0;
    end
    tick_now    = '0;
    armed_total = '0;
  endfunction

  function automatic void disarm_slot(int s);
    if (slot_armed[s]) begin
      slot_armed[s] = 1'b0;
      if (armed_total != 0) armed_total--;
    end
  endfunction

  // Stores a timer and arms it when a handler is present; returns the armed state.
  function automatic logic load_slot(int s, item_t w);
    slot_expiry[s] = w.expiry;
    slot_data[s]   = w.payload;
    slot_has_cb[s] = w.has_handler;
    if (!w.has_handler) return 1'b0;
    slot_armed[s] = 1'b1;
    armed_total++;
    return 1'b1;
  endfunction

  // Works out the result words of one accepted operation and queues them.
  function automatic void predict_operation(item_t w);
    int   s;
    logic flag;
    s    = int'(w.slot);
    flag = 1'b0;
    if (w.op == OP_TICK) begin
      tick_now++;
      // Slots fire in index order, each one disarmed before its word is built.
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_armed[i] && slot_expiry[i] <= tick_now) begin
          disarm_slot(i);
          pending_results.push_back(make_result(KIND_FIRE, 4'(i), slot_data[i], 1'b0, 1'b0));
        end
      end
      pending_results.push_back(make_result(KIND_DONE, '0, '0, 1'b0, 1'b1));
    end else begin
      case (w.op)
        OP_INIT: begin
          disarm_slot(s);
          slot_expiry[s] = '0;
          slot_data[s]   = '0;
          slot_has_cb[s] = 1'b0;
        end
        OP_ADD: begin
          if (!slot_armed[s]) flag = load_slot(s, w);
        end
        OP_DELETE: begin
          flag = slot_armed[s];
          disarm_slot(s);
        end
        OP_MODIFY: begin
          flag = slot_armed[s];
          disarm_slot(s);
          void'(load_slot(s, w));
        end
        default: begin
        end
      endcase
      pending_results.push_back(make_result(KIND_DONE, w.slot, '0, flag, 1'b1));
    end
  endfunction

  // Compares one result word with the oldest predicted word.
  task automatic check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      $error("result word with nothing expected: kind %0d slot %0d", got.kind, got.fired_slot);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      mismatches++;
    end
    if (got.fired_slot !== want.fired_slot) begin
      $error("fired_slot: expected %0d, got %0d", want.fired_slot, got.fired_slot);
      mismatches++;
    end
    if (got.fired_data !== want.fired_data) begin
      $error("fired_data: expected %h, got %h", want.fired_data, got.fired_data);
      mismatches++;
    end
    if (got.flag !== want.flag) begin
      $error("flag: expected %0d, got %0d", want.flag, got.flag);
      mismatches++;
    end
    if (got.now !== want.now) begin
      $error("now: expected %0d, got %0d", want.now, got.now);
      mismatches++;
    end
    if (got.armed_count !== want.armed_count) begin
      $error("armed_count: expected %0d, got %0d", want.armed_count, got.armed_count);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      mismatches++;
    end
  endtask

  // Result words cannot be stalled, so every strobe is checked at once.
  always @(posedge clk) begin
    if (!rst && result_strobe) check_result(result);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timer_table_expiry_scan: mismatch");
      $finish;
    end
  end

  // Presents one word and holds it until the block takes it.
  // Start stays high afterwards so a following word can go out back to back.
  task automatic send_word(item_t w);
    item  <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_operation(w);
  endtask

  task automatic idle_for(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(0, 3) == 0) idle_for($urandom_range(1, 10));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Each operation on its own, with refused, repeated and extreme cases.
  task automatic test_slot_operations();
    send_word(make_item(OP_INIT, 0, '0, '0, 1'b1));
    // Add without a handler is refused and leaves the slot idle.
    send_word(make_item(OP_ADD, 3, 32'd5, 32'h1234_5678, 1'b0));
    send_word(make_item(OP_ADD, 3, 32'd2, 32'hFFFF_FFFF, 1'b1));
    // A second add on an armed slot changes nothing.
    send_word(make_item(OP_ADD, 3, 32'd9, 32'h0BAD_0BAD, 1'b1));
    send_word(make_item(OP_MODIFY, 3, 32'd4, 32'h0000_0000, 1'b1));
    send_word(make_item(OP_MODIFY, 5, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 1'b1));
    send_word(make_item(OP_MODIFY, 6, 32'd1, 32'h0F0F_0F0F, 1'b0));
    send_word(make_item(OP_DELETE, 3, '0, '0, 1'b0));
    send_word(make_item(OP_DELETE, 3, '0, '0, 1'b0));
    // Expiry zero is already due at the first tick.
    send_word(make_item(OP_ADD, 15, 32'd0, 32'hA5A5_A5A5, 1'b1));
    send_word(make_item(OP_UNUSED_LO, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    send_word(make_item(OP_UNUSED_HI, 15, '0, '0, 1'b0));
    // Init on an armed slot drops the armed count.
    send_word(make_item(OP_INIT, 5, '0, '0, 1'b0));
    send_word(make_item(OP_TICK, 0, '0, '0, 1'b0));
    send_word(make_item(OP_TICK, 9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    wait_drained();
  endtask

  // Every slot due on the same tick gives the longest burst of fire words.
  task automatic test_full_expiry_scan();
    for (int s = 0; s < NUM_SLOTS; s++)
      send_word(make_item(OP_MODIFY, s, tick_now + 32'd1, $urandom, 1'b1));
    send_word(make_item(OP_TICK, 0, '0, '0, 1'b0));
    send_word(make_item(OP_TICK, 0, '0, '0, 1'b0));
    wait_drained();
  endtask

  // Mostly timers set a few ticks ahead, so that scans keep finding due slots.
  function automatic item_t random_word();
    int          pick;
    logic [31:0] due;
    pick = $urandom_range(0, 99);
    due  = ($urandom_range(0, 4) == 0) ? $urandom : tick_now + $urandom_range(0, 6);
    if (pick < 30)
      return make_item(OP_TICK, $urandom_range(0, 15), $urandom, $urandom, 1'($urandom));
    if (pick < 55)
      return make_item(OP_ADD, $urandom_range(0, 15), due, $urandom, $urandom_range(0, 7) != 0);
    if (pick < 70)
      return make_item(OP_MODIFY, $urandom_range(0, 15), due, $urandom,
                       $urandom_range(0, 7) != 0);
    if (pick < 80)
      return make_item(OP_DELETE, $urandom_range(0, 15), $urandom, $urandom, 1'($urandom));
    if (pick < 88)
      return make_item(OP_INIT, $urandom_range(0, 15), $urandom, $urandom, 1'($urandom));
    if (pick < 94)
      return make_item(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), $urandom_range(0, 15),
                       $urandom, $urandom, 1'($urandom));
    // Raw noise over the whole word.
    return make_item(3'($urandom), $urandom_range(0, 15), $urandom, $urandom, 1'($urandom));
  endfunction

  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      send_word(random_word());
      // Halfway through, the sender holds off until the block has gone quiet.
      if (i == RANDOM_WORDS / 2) wait_drained();
      else if (i < RANDOM_WORDS - BURST_TAIL) maybe_idle();
    end
    wait_drained();
  endtask

  initial begin
    clear_table();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_slot_operations();
    test_full_expiry_scan();
    test_random_traffic();
    // Catch any stray word after the last expected one.
    repeat (SCAN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("timer_table_expiry_scan: match");
    end else begin
      $display("timer_table_expiry_scan: mismatch");
    end
    $finish;
  end

endmodule
